// File: src/arp_cache_resolver_responder_top_macros.svh
// assertion macros for the arp resolver
`ifndef ARP_CACHE_RESOLVER_RESPONDER_TOP_MACROS_SVH
`define ARP_CACHE_RESOLVER_RESPONDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define ARPCR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("arpcr: invariant violated");
// property that relates one edge to the next
`define ARPCR_ASSERT_SEQ(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("arpcr: sequence violated");
`else
`define ARPCR_ASSERT(lbl, clk, rstn, prop)
`define ARPCR_ASSERT_SEQ(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: src/arpcr_pkg.sv
`timescale 1ns / 1ps
package arpcr_pkg;

  // command codes of an input transaction
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_FRAME  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_RESOLVED = 2'd0;
  localparam logic [1:0] KIND_REQUEST  = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd2;
  localparam logic [1:0] KIND_REPLY    = 2'd3;

  // arp opcodes
  localparam logic [15:0] OP_REQUEST = 16'h0001;
  localparam logic [15:0] OP_REPLY   = 16'h0002;

  // configuration register indexes
  localparam logic [1:0] REG_OWN_IP     = 2'd0;
  localparam logic [1:0] REG_OWN_MAC    = 2'd1;
  localparam logic [1:0] REG_GATEWAY_IP = 2'd2;
  localparam logic [1:0] REG_WAIT_LIMIT = 2'd3;

  localparam logic [31:0] SUBNET_MASK   = 32'hffff_ff00;
  localparam logic [47:0] MAC_BCAST     = 48'hffff_ffff_ffff;
  localparam logic [16:0] TICKS_MAX     = 17'h1_ffff;
  localparam logic [15:0] WAIT_LIMIT_RST = 16'd100;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] lookup_ip;
    logic [47:0] frame_dest_mac;
    logic [47:0] frame_src_mac;
    logic [15:0] arp_opcode;
    logic [31:0] arp_sender_ip;
    logic [31:0] arp_target_ip;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [47:0] mac;
    logic [31:0] ip;
  } out_t;

endpackage

// File: src/arp_cache_resolver_responder_top.sv
`timescale 1ns / 1ps
// ARP resolver and responder with an append-only IPv4-to-MAC table.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries lookups, received
// ARP frames and timer ticks; output channel (out_valid_o/out_ready_i,
// out_data_o) carries zero or one result per input transaction.
// Configuration is written through cfg_we_i/cfg_addr_i/cfg_wdata_i with no
// wait; write it only while the block is idle.
// Ticks and frames complete in the cycle they are accepted; their result
// sits in the output register in the next cycle. A lookup with an empty
// table answers the same way. Otherwise the lookup scans the filled entries
// through the table memory, one compare per cycle behind one registered read;
// a hit ends the scan at the matching entry, a miss after the last filled
// entry. The block takes one transaction at a time and is not ready during
// a scan.
// Reset clears the fill count, the wait state and the output valid flag;
// the table contents stay undefined but only filled entries are ever compared.
// When the receiver stalls, the result holds in the output register and no
// new input transaction is accepted until it has been taken.
`include "arp_cache_resolver_responder_top_macros.svh"

module arp_cache_resolver_responder_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  arpcr_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output arpcr_pkg::out_t out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_addr_i,
  input  logic [47:0]     cfg_wdata_i
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  // configuration registers
  logic [31:0] own_ip_q;
  logic [47:0] own_mac_q;
  logic [31:0] gateway_ip_q;
  logic [15:0] wait_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q     <= '0;
      own_mac_q    <= '0;
      gateway_ip_q <= '0;
      wait_limit_q <= arpcr_pkg::WAIT_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        arpcr_pkg::REG_OWN_IP:     own_ip_q     <= cfg_wdata_i[31:0];
        arpcr_pkg::REG_OWN_MAC:    own_mac_q    <= cfg_wdata_i;
        arpcr_pkg::REG_GATEWAY_IP: gateway_ip_q <= cfg_wdata_i[31:0];
        arpcr_pkg::REG_WAIT_LIMIT: wait_limit_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // control and wait state
  logic             state_q, state_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic             rd_last_q, rd_last_d;
  logic             waiting_q, waiting_d;
  logic [16:0]      ticks_q, ticks_d;
  logic [31:0]      pending_ip_q, pending_ip_d;
  logic [31:0]      dst_q, dst_d;
  logic             out_valid_q, out_valid_d;
  arpcr_pkg::out_t  out_q, out_d;

  // table memory
  entry_t           mem_q [TABLE_DEPTH];
  entry_t           rd_q;
  logic             mem_we;
  entry_t           mem_wdata;

  logic             in_fire;
  logic             out_free;
  logic [31:0]      route_ip;
  logic [16:0]      ticks_inc;
  logic             issue;
  logic             hit;
  logic             miss;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // destination routing: off-subnet goes to the gateway
  assign route_ip = ((in_data_i.lookup_ip & arpcr_pkg::SUBNET_MASK) !=
                     (own_ip_q & arpcr_pkg::SUBNET_MASK)) ? gateway_ip_q
                                                          : in_data_i.lookup_ip;

  // saturating tick count
  assign ticks_inc = (ticks_q == arpcr_pkg::TICKS_MAX) ? ticks_q : ticks_q + 17'd1;

  // scan: one read issued and one compare per cycle
  assign issue = (state_q == ST_SCAN) && (idx_q < fill_q);
  assign hit   = rd_vld_q && (rd_q.ip == dst_q);
  assign miss  = rd_vld_q && rd_last_q && !hit;

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    idx_d        = idx_q;
    rd_vld_d     = 1'b0;
    rd_last_d    = rd_last_q;
    waiting_d    = waiting_q;
    ticks_d      = ticks_q;
    pending_ip_d = pending_ip_q;
    dst_d        = dst_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_wdata.ip  = in_data_i.arp_sender_ip;
    mem_wdata.mac = in_data_i.frame_src_mac;

    if (state_q == ST_SCAN) begin
      if (issue && !hit) begin
        idx_d     = CNT_W'(idx_q + 1'b1);
        rd_vld_d  = 1'b1;
        rd_last_d = (CNT_W'(idx_q + 1'b1) == fill_q);
      end
      if (hit) begin
        out_valid_d = 1'b1;
        out_d       = '{result_kind: arpcr_pkg::KIND_RESOLVED, mac: rd_q.mac, ip: dst_q};
        state_d     = ST_IDLE;
      end else if (miss) begin
        out_valid_d  = 1'b1;
        out_d        = '{result_kind: arpcr_pkg::KIND_REQUEST,
                         mac: arpcr_pkg::MAC_BCAST, ip: dst_q};
        waiting_d    = 1'b1;
        ticks_d      = '0;
        pending_ip_d = dst_q;
        state_d      = ST_IDLE;
      end
    end else if (in_fire) begin
      case (in_data_i.command)
        arpcr_pkg::CMD_LOOKUP: begin
          if (!waiting_q) begin
            dst_d = route_ip;
            if (fill_q == '0) begin
              out_valid_d  = 1'b1;
              out_d        = '{result_kind: arpcr_pkg::KIND_REQUEST,
                               mac: arpcr_pkg::MAC_BCAST, ip: route_ip};
              waiting_d    = 1'b1;
              ticks_d      = '0;
              pending_ip_d = route_ip;
            end else begin
              idx_d   = '0;
              state_d = ST_SCAN;
            end
          end
        end
        arpcr_pkg::CMD_TICK: begin
          if (waiting_q) begin
            ticks_d = ticks_inc;
            if (ticks_inc > {1'b0, wait_limit_q}) begin
              waiting_d   = 1'b0;
              out_valid_d = 1'b1;
              out_d       = '{result_kind: arpcr_pkg::KIND_TIMEOUT,
                              mac: arpcr_pkg::MAC_BCAST, ip: pending_ip_q};
            end
          end
        end
        arpcr_pkg::CMD_FRAME: begin
          if (in_data_i.frame_dest_mac == own_mac_q) begin
            if (in_data_i.arp_opcode == arpcr_pkg::OP_REPLY && fill_q < DEPTH_C) begin
              mem_we = 1'b1;
              fill_d = CNT_W'(fill_q + 1'b1);
              if (waiting_q) begin
                waiting_d   = 1'b0;
                out_valid_d = 1'b1;
                out_d       = '{result_kind: arpcr_pkg::KIND_RESOLVED,
                                mac: in_data_i.frame_src_mac, ip: pending_ip_q};
              end
            end
          end else if (in_data_i.frame_dest_mac == arpcr_pkg::MAC_BCAST &&
                       in_data_i.arp_opcode == arpcr_pkg::OP_REQUEST &&
                       in_data_i.arp_target_ip == own_ip_q) begin
            out_valid_d = 1'b1;
            out_d       = '{result_kind: arpcr_pkg::KIND_REPLY,
                            mac: in_data_i.frame_src_mac, ip: in_data_i.arp_sender_ip};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      idx_q        <= '0;
      rd_vld_q     <= 1'b0;
      rd_last_q    <= 1'b0;
      waiting_q    <= 1'b0;
      ticks_q      <= '0;
      pending_ip_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      idx_q        <= idx_d;
      rd_vld_q     <= rd_vld_d;
      rd_last_q    <= rd_last_d;
      waiting_q    <= waiting_d;
      ticks_q      <= ticks_d;
      pending_ip_q <= pending_ip_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dst_q <= dst_d;
    out_q <= out_d;
  end

  // table write at the fill position, registered read at the scan index
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[fill_q[IDX_W-1:0]] <= mem_wdata;
    end
    rd_q <= mem_q[idx_q[IDX_W-1:0]];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `ARPCR_ASSERT(a_scan_out_empty, clk_i, rst_ni, (state_q == ST_SCAN) |-> !out_valid_q)
  `ARPCR_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= DEPTH_C)
  `ARPCR_ASSERT(a_read_in_scan, clk_i, rst_ni, rd_vld_q |-> (state_q == ST_SCAN))
  `ARPCR_ASSERT(a_request_waits, clk_i, rst_ni,
    (out_valid_q && out_q.result_kind == arpcr_pkg::KIND_REQUEST) |-> waiting_q)
  `ARPCR_ASSERT_SEQ(a_scan_ends_with_result, clk_i, rst_ni,
    (state_q == ST_SCAN && (hit || miss)), (out_valid_q && state_q == ST_IDLE))

endmodule

// File: verif/arp_cache_resolver_responder_top_tb.sv
`timescale 1ns / 1ps
module arp_cache_resolver_responder_top_tb;

  localparam int TABLE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // dut connections, inputs known from time zero
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  arpcr_pkg::in_t    in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  arpcr_pkg::out_t   out_data_o;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_addr_i = arpcr_pkg::REG_OWN_IP;
  logic [47:0]       cfg_wdata_i = '0;

  // station settings as last written
  logic [31:0] st_ip = 32'd0;
  logic [47:0] st_mac = 48'd0;
  logic [31:0] st_gw = 32'd0;
  logic [15:0] st_wait_limit = arpcr_pkg::WAIT_LIMIT_RST;

  // predicted cache and resolve state
  logic [31:0] cache_ip [TABLE_DEPTH];
  logic [47:0] cache_mac [TABLE_DEPTH];
  int          cache_fill = 0;
  bit          resolving = 1'b0;
  logic [16:0] resolve_ticks = '0;
  logic [31:0] resolve_ip = '0;

  arpcr_pkg::out_t arp_answers_q[$];
  int          mismatch_count = 0;
  int          sent_count = 0;
  int          cycle_count = 0;
  int          stall_len = 0;
  bit          steady = 1'b0;

  arp_cache_resolver_responder_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** arp_cache_resolver_responder_top: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    mismatch_count++;
    if (mismatch_count <= 60)
      $display("%0t: %s mismatch: got %h want %h", $time, what, got, want);
  endtask

  // next answer of the resolver for one accepted transaction
  function automatic bit predict_arp_answer(input arpcr_pkg::in_t item,
                                            output arpcr_pkg::out_t answer);
    logic [31:0] dst;
    int          hit;
    int          k;
    answer = '0;
    hit = -1;
    if (item.command == arpcr_pkg::CMD_LOOKUP) begin
      if (resolving) return 1'b0;
      dst = item.lookup_ip;
      // off-subnet destinations go through the gateway
      if ((dst & arpcr_pkg::SUBNET_MASK) != (st_ip & arpcr_pkg::SUBNET_MASK)) dst = st_gw;
      for (k = 0; k < cache_fill; k++)
        if (hit < 0 && cache_ip[k] == dst) hit = k;
      answer.ip = dst;
      if (hit >= 0) begin
        answer.result_kind = arpcr_pkg::KIND_RESOLVED;
        answer.mac = cache_mac[hit];
      end else begin
        resolving = 1'b1;
        resolve_ticks = '0;
        resolve_ip = dst;
        answer.result_kind = arpcr_pkg::KIND_REQUEST;
        answer.mac = arpcr_pkg::MAC_BCAST;
      end
      return 1'b1;
    end
    if (item.command == arpcr_pkg::CMD_TICK) begin
      if (!resolving) return 1'b0;
      if (resolve_ticks != arpcr_pkg::TICKS_MAX) resolve_ticks++;
      if (resolve_ticks > {1'b0, st_wait_limit}) begin
        resolving = 1'b0;
        answer.result_kind = arpcr_pkg::KIND_TIMEOUT;
        answer.mac = arpcr_pkg::MAC_BCAST;
        answer.ip = resolve_ip;
        return 1'b1;
      end
      return 1'b0;
    end
    if (item.command == arpcr_pkg::CMD_FRAME) begin
      // own mac is tested first, even when it is the broadcast address
      if (item.frame_dest_mac == st_mac) begin
        if (item.arp_opcode == arpcr_pkg::OP_REPLY && cache_fill < TABLE_DEPTH) begin
          cache_mac[cache_fill] = item.frame_src_mac;
          cache_ip[cache_fill] = item.arp_sender_ip;
          cache_fill++;
          if (resolving) begin
            resolving = 1'b0;
            answer.result_kind = arpcr_pkg::KIND_RESOLVED;
            answer.mac = item.frame_src_mac;
            answer.ip = resolve_ip;
            return 1'b1;
          end
        end
        return 1'b0;
      end
      if (item.frame_dest_mac == arpcr_pkg::MAC_BCAST &&
          item.arp_opcode == arpcr_pkg::OP_REQUEST &&
          item.arp_target_ip == st_ip) begin
        answer.result_kind = arpcr_pkg::KIND_REPLY;
        answer.mac = item.frame_src_mac;
        answer.ip = item.arp_sender_ip;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // transaction builders
  function automatic logic [47:0] rand_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic [31:0] subnet_ip();
    return (st_ip & arpcr_pkg::SUBNET_MASK) | {24'd0, 8'($urandom)};
  endfunction

  function automatic arpcr_pkg::in_t noise_fields();
    arpcr_pkg::in_t it;
    it.command = 2'($urandom_range(0, 3));
    it.lookup_ip = $urandom;
    it.frame_dest_mac = rand_mac();
    it.frame_src_mac = rand_mac();
    it.arp_opcode = 16'($urandom);
    it.arp_sender_ip = $urandom;
    it.arp_target_ip = $urandom;
    return it;
  endfunction

  function automatic arpcr_pkg::in_t lookup_item(logic [31:0] ip);
    arpcr_pkg::in_t it;
    it = noise_fields();
    it.command = arpcr_pkg::CMD_LOOKUP;
    it.lookup_ip = ip;
    return it;
  endfunction

  function automatic arpcr_pkg::in_t tick_item();
    arpcr_pkg::in_t it;
    it = noise_fields();
    it.command = arpcr_pkg::CMD_TICK;
    return it;
  endfunction

  function automatic arpcr_pkg::in_t frame_item(logic [47:0] dest, logic [47:0] src,
                                                logic [15:0] op, logic [31:0] sender,
                                                logic [31:0] target);
    arpcr_pkg::in_t it;
    it = noise_fields();
    it.command = arpcr_pkg::CMD_FRAME;
    it.frame_dest_mac = dest;
    it.frame_src_mac = src;
    it.arp_opcode = op;
    it.arp_sender_ip = sender;
    it.arp_target_ip = target;
    return it;
  endfunction

  // transactions the block should drop or that break a sequence
  function automatic arpcr_pkg::in_t stray_item();
    arpcr_pkg::in_t it;
    it = noise_fields();
    case ($urandom_range(0, 5))
      0: ;
      1: begin
        it.command = arpcr_pkg::CMD_FRAME;
        it.frame_dest_mac = arpcr_pkg::MAC_BCAST;
        it.arp_opcode = arpcr_pkg::OP_REQUEST;
        it.arp_target_ip = st_ip ^ (32'd1 << $urandom_range(0, 31));
      end
      2: begin
        it.command = arpcr_pkg::CMD_FRAME;
        it.frame_dest_mac = st_mac;
      end
      3: begin
        it.command = arpcr_pkg::CMD_FRAME;
        it.frame_dest_mac = arpcr_pkg::MAC_BCAST;
        it.arp_target_ip = st_ip;
      end
      4: it.command = arpcr_pkg::CMD_TICK;
      default: it.command = CMD_UNUSED;
    endcase
    return it;
  endfunction

  function automatic logic [31:0] entry_candidate();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return $urandom;
    if (r == 1 && cache_fill > 0) return cache_ip[$urandom_range(0, cache_fill - 1)];
    return subnet_ip();
  endfunction

  // offer one transaction, predict its answer once it is taken
  task automatic offer_item(arpcr_pkg::in_t item);
    arpcr_pkg::out_t answer;
    bit              has_answer;
    if (!in_valid_i) in_valid_i <= 1'b1;
    in_data_i <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    has_answer = predict_arp_answer(item, answer);
    if (has_answer) arp_answers_q.push_back(answer);
    sent_count++;
    if (!steady && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // drain outstanding answers plus the longest scan
  task automatic wait_until_quiet();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (arp_answers_q.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic program_station(logic [31:0] ip, logic [47:0] mac, logic [31:0] gw,
                                 logic [15:0] limit);
    wait_until_quiet();
    cfg_we_i <= 1'b1;
    cfg_addr_i <= arpcr_pkg::REG_OWN_IP;
    cfg_wdata_i <= {16'd0, ip};
    @(posedge clk_i);
    cfg_addr_i <= arpcr_pkg::REG_OWN_MAC;
    cfg_wdata_i <= mac;
    @(posedge clk_i);
    cfg_addr_i <= arpcr_pkg::REG_GATEWAY_IP;
    cfg_wdata_i <= {16'd0, gw};
    @(posedge clk_i);
    cfg_addr_i <= arpcr_pkg::REG_WAIT_LIMIT;
    cfg_wdata_i <= {32'd0, limit};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    st_ip = ip;
    st_mac = mac;
    st_gw = gw;
    st_wait_limit = limit;
  endtask

  // lookup, then after a miss ticks and stray items until timeout or a reply
  task automatic resolve_sequence();
    bit answer_it;
    int r;
    if (!resolving)
      offer_item(lookup_item(($urandom_range(0, 3) == 0) ? $urandom : subnet_ip()));
    if (resolving && $urandom_range(0, 3) == 0) offer_item(lookup_item($urandom));
    answer_it = ($urandom_range(0, 5) == 0);
    while (resolving) begin
      r = $urandom_range(0, 99);
      if (answer_it && r < 20) begin
        answer_it = 1'b0;
        offer_item(frame_item(st_mac, rand_mac(), arpcr_pkg::OP_REPLY,
                              ($urandom_range(0, 3) == 0) ? $urandom : resolve_ip,
                              $urandom));
      end else if (r < 10) begin
        offer_item(stray_item());
      end else begin
        offer_item(tick_item());
      end
    end
  endtask

  task automatic run_traffic(int count);
    int goal;
    int r;
    goal = sent_count + count;
    while (sent_count < goal) begin
      r = $urandom_range(0, 99);
      if (r < 30 && cache_fill > 0)
        offer_item(lookup_item(cache_ip[$urandom_range(0, cache_fill - 1)]));
      else if (r < 55)
        resolve_sequence();
      else if (r < 68)
        offer_item(frame_item(arpcr_pkg::MAC_BCAST, rand_mac(), arpcr_pkg::OP_REQUEST,
                              $urandom, st_ip));
      else if (r < 71)
        offer_item(frame_item(st_mac, rand_mac(), arpcr_pkg::OP_REPLY, entry_candidate(),
                              $urandom));
      else
        offer_item(stray_item());
    end
  endtask

  // receiver: random stalls, optional long hold-off
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (stall_len != 0) begin
        hold = stall_len;
        stall_len = 0;
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= steady || ($urandom_range(0, 99) >= 19);
    end
  end

  // compare every taken result with the oldest prediction
  always @(posedge clk_i) begin
    arpcr_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (arp_answers_q.size() == 0) begin
        report_mismatch("unexpected result", {14'd0, out_data_o.result_kind,
                        out_data_o.ip}, '0);
      end else begin
        want = arp_answers_q.pop_front();
        if (out_data_o.result_kind !== want.result_kind)
          report_mismatch("result_kind", {46'd0, out_data_o.result_kind},
                          {46'd0, want.result_kind});
        if (out_data_o.mac !== want.mac)
          report_mismatch("mac", out_data_o.mac, want.mac);
        if (out_data_o.ip !== want.ip)
          report_mismatch("ip", {16'd0, out_data_o.ip}, {16'd0, want.ip});
      end
    end
  end

  // reset register values: idle tick, unused command, replies to ip 0
  task automatic test_reset_values();
    arpcr_pkg::in_t it;
    offer_item(tick_item());
    it = '1;
    it.command = CMD_UNUSED;
    offer_item(it);
    offer_item(frame_item(arpcr_pkg::MAC_BCAST, arpcr_pkg::MAC_BCAST, arpcr_pkg::OP_REQUEST,
                          32'hffff_ffff, 32'h0));
    offer_item(frame_item(48'h0, rand_mac(), arpcr_pkg::OP_REQUEST, $urandom, $urandom));
  endtask

  // miss, lookup dropped while waiting, zero wait limit
  task automatic test_miss_and_timeout();
    program_station(32'hc0a8_0a05, rand_mac(), 32'hc0a8_0a01, 16'd0);
    offer_item(lookup_item(32'hc0a8_0a63));
    offer_item(lookup_item(32'hffff_ffff));
    offer_item(tick_item());
    offer_item(tick_item());
  endtask

  // off-subnet lookup resolved through the gateway
  task automatic test_gateway_route();
    offer_item(lookup_item(32'h0000_0000));
    offer_item(frame_item(st_mac, rand_mac(), arpcr_pkg::OP_REPLY, st_gw, 32'hffff_ffff));
    offer_item(lookup_item(32'h0808_0808));
  endtask

  // idle reply appended, request answered, other frames dropped
  task automatic test_frame_filters();
    offer_item(frame_item(st_mac, rand_mac(), arpcr_pkg::OP_REPLY, 32'hc0a8_0a20, $urandom));
    offer_item(lookup_item(32'hc0a8_0a20));
    offer_item(frame_item(arpcr_pkg::MAC_BCAST, rand_mac(), arpcr_pkg::OP_REQUEST,
                          $urandom, st_ip));
    offer_item(frame_item(arpcr_pkg::MAC_BCAST, rand_mac(), arpcr_pkg::OP_REQUEST,
                          $urandom, st_ip ^ 32'd1));
    offer_item(frame_item(arpcr_pkg::MAC_BCAST, rand_mac(), arpcr_pkg::OP_REPLY,
                          $urandom, st_ip));
    offer_item(frame_item(st_mac ^ 48'd1, rand_mac(), arpcr_pkg::OP_REPLY,
                          $urandom, $urandom));
    offer_item(frame_item(st_mac, rand_mac(), 16'hffff, $urandom, $urandom));
  endtask

  // station mac all ones, maximum wait limit
  task automatic test_broadcast_station_mac();
    program_station(32'hffff_ffff, arpcr_pkg::MAC_BCAST, 32'hffff_ffff, 16'hffff);
    offer_item(frame_item(arpcr_pkg::MAC_BCAST, rand_mac(), arpcr_pkg::OP_REQUEST,
                          $urandom, st_ip));
    offer_item(lookup_item(32'hffff_ff7a));
    repeat (3) offer_item(tick_item());
    offer_item(frame_item(arpcr_pkg::MAC_BCAST, 48'h0, arpcr_pkg::OP_REPLY,
                          32'hffff_ff7a, 32'h0));
    offer_item(lookup_item(32'hffff_ff7a));
  endtask

  task automatic test_random_in_subnet();
    program_station({24'hc0a80a, 8'($urandom)}, rand_mac(), 32'hc0a8_0a01,
                    16'($urandom_range(0, 6)));
    run_traffic(400);
  endtask

  // no idling on either side
  task automatic test_random_steady();
    steady = 1'b1;
    program_station({24'hc0a80a, 8'($urandom)}, rand_mac(), {8'h0a, 24'($urandom)},
                    16'd12);
    run_traffic(350);
    steady = 1'b0;
  endtask

  // receiver holds off while transactions keep coming
  task automatic test_output_backpressure();
    stall_len = 150;
    repeat (12)
      offer_item(frame_item(arpcr_pkg::MAC_BCAST, rand_mac(), arpcr_pkg::OP_REQUEST,
                            $urandom, st_ip));
    repeat (4) offer_item(lookup_item(cache_ip[$urandom_range(0, cache_fill - 1)]));
  endtask

  // foreign subnet, gateway pointing at a cached entry
  task automatic test_random_routed();
    program_station(32'h0a00_0001, rand_mac(), 32'hc0a8_0a20, 16'd3);
    run_traffic(350);
  endtask

  task automatic test_random_edge_host();
    program_station(32'hc0a8_0aff, rand_mac(), 32'hc0a8_0a01, 16'($urandom_range(0, 10)));
    run_traffic(330);
  endtask

  // main sequence
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_miss_and_timeout();
    test_gateway_route();
    test_frame_filters();
    test_broadcast_station_mac();
    test_random_in_subnet();
    test_random_steady();
    test_output_backpressure();
    test_random_routed();
    test_random_edge_host();
    wait_until_quiet();
    if (mismatch_count == 0)
      $display("** arp_cache_resolver_responder_top: PASSED **");
    else
      $display("** arp_cache_resolver_responder_top: FAILED **");
    $finish;
  end

endmodule
